// ===== design/connect_packet_framer_defines.svh =====
// assertion macros for the connect packet framer
`ifndef CONNECT_PACKET_FRAMER_DEFINES_SVH
`define CONNECT_PACKET_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
`define CPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CPF_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);
`else
`define CPF_ASSERT(lbl, prop, msg)
`define CPF_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif

`endif

// ===== design/cpf_pkg.sv =====
`timescale 1ns / 1ps

package cpf_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 3;
    localparam int SLOT_W  = 3;
    localparam int ACC_W   = 19;
    localparam int PC_W    = 5;
    localparam int VAR_SH  = 7;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    localparam logic [IDX_W-1:0] REG_OPTIONS      = 3'd0;
    localparam logic [IDX_W-1:0] REG_KA_SECS      = 3'd1;
    localparam logic [IDX_W-1:0] REG_CLIENT_LEN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_TOPIC_LEN    = 3'd3;
    localparam logic [IDX_W-1:0] REG_MESSAGE_LEN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_USER_LEN     = 3'd5;
    localparam logic [IDX_W-1:0] REG_PASSWORD_LEN = 3'd6;

    localparam logic [SLOT_W-1:0] SLOT_CLIENT   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_TOPIC    = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_MESSAGE  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_USER     = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_PASSWORD = 3'd4;

    localparam logic [BYTE_W-1:0] HDR_CONNECT = 8'h10;
    localparam logic [BYTE_W-1:0] NAME_LEN_HI = 8'h00;
    localparam logic [BYTE_W-1:0] NAME_LEN_LO = 8'h04;
    localparam logic [BYTE_W-1:0] CHAR_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CHAR_Q      = 8'h51;
    localparam logic [BYTE_W-1:0] CHAR_T      = 8'h54;
    localparam logic [BYTE_W-1:0] PROTO_LEVEL = 8'h04;
    localparam logic [ACC_W-1:0]  REM_BASE    = 19'd10;
    localparam logic [ACC_W-1:0]  PREFIX_LEN  = 19'd2;
    localparam logic [1:0]        QOS_INVALID = 2'd3;

    localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] PC_REJECT   = 5'd1;
    localparam logic [PC_W-1:0] PC_DATA     = 5'd2;
    localparam logic [PC_W-1:0] PC_START    = 5'd3;
    localparam logic [PC_W-1:0] PC_ACC      = 5'd4;
    localparam logic [PC_W-1:0] PC_HDR      = 5'd5;
    localparam logic [PC_W-1:0] PC_VAR      = 5'd6;
    localparam logic [PC_W-1:0] PC_NAME_HI  = 5'd7;
    localparam logic [PC_W-1:0] PC_NAME_LO  = 5'd8;
    localparam logic [PC_W-1:0] PC_NAME_M   = 5'd9;
    localparam logic [PC_W-1:0] PC_NAME_Q   = 5'd10;
    localparam logic [PC_W-1:0] PC_NAME_T1  = 5'd11;
    localparam logic [PC_W-1:0] PC_NAME_T2  = 5'd12;
    localparam logic [PC_W-1:0] PC_LEVEL    = 5'd13;
    localparam logic [PC_W-1:0] PC_FLAGS    = 5'd14;
    localparam logic [PC_W-1:0] PC_KA_HI    = 5'd15;
    localparam logic [PC_W-1:0] PC_KA_LO    = 5'd16;
    localparam logic [PC_W-1:0] PC_OPEN     = 5'd17;
    localparam logic [PC_W-1:0] PC_PFX_HI   = 5'd18;
    localparam logic [PC_W-1:0] PC_PFX_LO   = 5'd19;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_REJECT,
        OP_DATA,
        OP_ACC_INIT,
        OP_ACC_ADD,
        OP_CONST,
        OP_VARINT,
        OP_FLAGS,
        OP_KA_HI,
        OP_KA_LO,
        OP_SKIP,
        OP_PFX_HI,
        OP_PFX_LO
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BYTE_W-1:0] lit;
        logic [PC_W-1:0]  jmp;
    } ctrl_t;

    function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = '{op: OP_IDLE, lit: '0, jmp: PC_IDLE};
        case (pc)
            PC_IDLE:    c.op = OP_IDLE;
            PC_REJECT:  c.op = OP_REJECT;
            PC_DATA:    c = '{op: OP_DATA, lit: '0, jmp: PC_OPEN};
            PC_START:   c.op = OP_ACC_INIT;
            PC_ACC:     c.op = OP_ACC_ADD;
            PC_HDR:     c = '{op: OP_CONST, lit: HDR_CONNECT, jmp: PC_IDLE};
            PC_VAR:     c.op = OP_VARINT;
            PC_NAME_HI: c = '{op: OP_CONST, lit: NAME_LEN_HI, jmp: PC_IDLE};
            PC_NAME_LO: c = '{op: OP_CONST, lit: NAME_LEN_LO, jmp: PC_IDLE};
            PC_NAME_M:  c = '{op: OP_CONST, lit: CHAR_M, jmp: PC_IDLE};
            PC_NAME_Q:  c = '{op: OP_CONST, lit: CHAR_Q, jmp: PC_IDLE};
            PC_NAME_T1: c = '{op: OP_CONST, lit: CHAR_T, jmp: PC_IDLE};
            PC_NAME_T2: c = '{op: OP_CONST, lit: CHAR_T, jmp: PC_IDLE};
            PC_LEVEL:   c = '{op: OP_CONST, lit: PROTO_LEVEL, jmp: PC_IDLE};
            PC_FLAGS:   c.op = OP_FLAGS;
            PC_KA_HI:   c.op = OP_KA_HI;
            PC_KA_LO:   c.op = OP_KA_LO;
            PC_OPEN:    c.op = OP_SKIP;
            PC_PFX_HI:  c.op = OP_PFX_HI;
            PC_PFX_LO:  c = '{op: OP_PFX_LO, lit: '0, jmp: PC_OPEN};
            default:    c.op = OP_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== design/cpf_item_if.sv =====
`timescale 1ns / 1ps

interface cpf_item_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [cpf_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// ===== design/cpf_frame_if.sv =====
`timescale 1ns / 1ps

interface cpf_frame_if;
    logic                       valid;
    logic                       ready;
    logic [cpf_pkg::BYTE_W-1:0] out_byte;
    logic                       packet_end;
    logic                       last_of_run;
    logic                       rejected;

    modport source (output valid, output out_byte, output packet_end, output last_of_run,
                    output rejected, input ready);
    modport sink   (input valid, input out_byte, input packet_end, input last_of_run,
                    input rejected, output ready);
endinterface

// ===== design/cpf_cfg_if.sv =====
`timescale 1ns / 1ps

interface cpf_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [cpf_pkg::IDX_W-1:0] index;
    logic [cpf_pkg::LEN_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/connect_packet_framer.sv =====
`timescale 1ns / 1ps
// connect_packet_framer: byte-serial encoder of a protocol level 4 CONNECT frame.
// channels: item (sink) takes action/data_byte, frame (source) gives one frame byte
// per transfer with packet_end, last_of_run and rejected, cfg (sink) writes the
// options, keep alive and the five string lengths by register index; cfg is always
// ready; it is to be written only between items, which the block does not enforce.
// a start item runs a small microprogram: a clear step, then an add step for each of
// the five string slots to sum the remaining length, then one frame byte per cycle
// while frame is not stalled (header, 1 to 3 length bytes, name, level, flags, keep
// alive); each string prefix pair follows a lookup step and goes out high byte then
// low byte, and the lookup step passes over each absent string in turn.
// a payload byte item is accepted, then loaded into the output register at the data
// step; a string end adds a lookup step and high and low prefix steps per string,
// and the lookup step passes each absent string; a rejected item gives a single result.
// item is ready only while the sequencer sits at its idle step, so items go one at
// a time; a finished result in the output register does not block the next item.
// when frame is stalled the sequencer holds on its current emitting step.
// reset clears the sequencer, the packet state, the output register and all
// configuration registers; the block is idle and ready as soon as reset is released.
`include "connect_packet_framer_defines.svh"

module connect_packet_framer
(
    input  logic             clk,
    input  logic             rst_n,
    cpf_item_if.sink         item,
    cpf_frame_if.source      frame,
    cpf_cfg_if.sink          cfg
);

    logic [cpf_pkg::PC_W-1:0]   pc_reg, pc_next;
    logic [cpf_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [cpf_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [cpf_pkg::LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic                       packet_active_reg, packet_active_next;
    logic [cpf_pkg::BYTE_W-1:0] data_reg, data_next;

    logic [cpf_pkg::BYTE_W-1:0] opt_reg, opt_next;
    logic [cpf_pkg::LEN_W-1:0]  ka_reg, ka_next;
    logic [cpf_pkg::LEN_W-1:0]  len_reg [5];
    logic [cpf_pkg::LEN_W-1:0]  len_next [5];

    logic                       out_valid_reg, out_valid_next;
    logic [cpf_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       out_end_reg, out_end_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_rej_reg, out_rej_next;

    cpf_pkg::ctrl_t             ctrl;
    logic                       at_idle;
    logic                       can_emit;
    logic                       emit;
    logic [cpf_pkg::BYTE_W-1:0] emit_byte;
    logic                       emit_end;
    logic                       emit_last;
    logic                       emit_rej;
    logic [cpf_pkg::LEN_W-1:0]  len_sel;
    logic                       present;
    logic                       present_after;
    logic [1:0]                 qos;
    logic [cpf_pkg::BYTE_W-1:0] flags;
    logic                       var_more;

    assign ctrl       = cpf_pkg::rom(pc_reg);
    assign at_idle    = (pc_reg == cpf_pkg::PC_IDLE);
    assign can_emit   = !out_valid_reg || frame.ready;
    assign item.ready = at_idle;
    assign cfg.ready  = 1'b1;

    assign frame.valid       = out_valid_reg;
    assign frame.out_byte    = out_byte_reg;
    assign frame.packet_end  = out_end_reg;
    assign frame.last_of_run = out_last_reg;
    assign frame.rejected    = out_rej_reg;

    always_comb
    begin
        case (slot_reg)
            cpf_pkg::SLOT_CLIENT:   len_sel = len_reg[0];
            cpf_pkg::SLOT_TOPIC:    len_sel = len_reg[1];
            cpf_pkg::SLOT_MESSAGE:  len_sel = len_reg[2];
            cpf_pkg::SLOT_USER:     len_sel = len_reg[3];
            cpf_pkg::SLOT_PASSWORD: len_sel = len_reg[4];
            default:                len_sel = '0;
        endcase
    end

    always_comb
    begin
        case (slot_reg)
            cpf_pkg::SLOT_CLIENT:   present = 1'b1;
            cpf_pkg::SLOT_TOPIC:    present = opt_reg[4];
            cpf_pkg::SLOT_MESSAGE:  present = opt_reg[5];
            cpf_pkg::SLOT_USER:     present = opt_reg[6];
            cpf_pkg::SLOT_PASSWORD: present = opt_reg[7];
            default:                present = 1'b0;
        endcase
    end

    // any present string in a later slot
    assign present_after = |(opt_reg[7:4] >> slot_reg);

    assign qos   = opt_reg[2:1];
    assign flags = {opt_reg[6], opt_reg[7], opt_reg[0],
                    (qos == cpf_pkg::QOS_INVALID) ? 2'b00 : qos,
                    opt_reg[5] & opt_reg[4], opt_reg[3], 1'b0};

    assign var_more = (acc_reg >> cpf_pkg::VAR_SH) != '0;

    always_comb
    begin
        pc_next            = pc_reg;
        acc_next           = acc_reg;
        slot_next          = slot_reg;
        bytes_left_next    = bytes_left_reg;
        packet_active_next = packet_active_reg;
        data_next          = data_reg;
        opt_next           = opt_reg;
        ka_next            = ka_reg;
        len_next           = len_reg;
        out_valid_next     = out_valid_reg && !frame.ready;
        out_byte_next      = out_byte_reg;
        out_end_next       = out_end_reg;
        out_last_next      = out_last_reg;
        out_rej_next       = out_rej_reg;
        emit               = 1'b0;
        emit_byte          = '0;
        emit_end           = 1'b0;
        emit_last          = 1'b0;
        emit_rej           = 1'b0;

        if (cfg.valid)
        begin
            case (cfg.index)
                cpf_pkg::REG_OPTIONS:      opt_next    = cfg.data[cpf_pkg::BYTE_W-1:0];
                cpf_pkg::REG_KA_SECS:      ka_next     = cfg.data;
                cpf_pkg::REG_CLIENT_LEN:   len_next[0] = cfg.data;
                cpf_pkg::REG_TOPIC_LEN:    len_next[1] = cfg.data;
                cpf_pkg::REG_MESSAGE_LEN:  len_next[2] = cfg.data;
                cpf_pkg::REG_USER_LEN:     len_next[3] = cfg.data;
                cpf_pkg::REG_PASSWORD_LEN: len_next[4] = cfg.data;
                default:                   opt_next    = opt_reg;
            endcase
        end

        case (ctrl.op)
            cpf_pkg::OP_IDLE:
            begin
                if (item.valid)
                begin
                    data_next = item.data_byte;
                    if (item.action == cpf_pkg::ACT_START)
                        pc_next = packet_active_reg ? cpf_pkg::PC_REJECT : cpf_pkg::PC_START;
                    else
                        pc_next = packet_active_reg ? cpf_pkg::PC_DATA : cpf_pkg::PC_REJECT;
                end
            end
            cpf_pkg::OP_REJECT:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    emit_rej  = 1'b1;
                    pc_next   = cpf_pkg::PC_IDLE;
                end
            end
            cpf_pkg::OP_DATA:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = data_reg;
                    if (bytes_left_reg != '0)
                        bytes_left_next = bytes_left_reg - cpf_pkg::LEN_W'(1);
                    if (bytes_left_reg > cpf_pkg::LEN_W'(1))
                    begin
                        emit_last = 1'b1;
                        pc_next   = cpf_pkg::PC_IDLE;
                    end
                    else if (present_after)
                    begin
                        slot_next = slot_reg + cpf_pkg::SLOT_W'(1);
                        pc_next   = ctrl.jmp;
                    end
                    else
                    begin
                        emit_end           = 1'b1;
                        emit_last          = 1'b1;
                        packet_active_next = 1'b0;
                        slot_next          = cpf_pkg::SLOT_CLIENT;
                        bytes_left_next    = '0;
                        pc_next            = cpf_pkg::PC_IDLE;
                    end
                end
            end
            cpf_pkg::OP_ACC_INIT:
            begin
                acc_next  = cpf_pkg::REM_BASE;
                slot_next = cpf_pkg::SLOT_CLIENT;
                pc_next   = pc_reg + cpf_pkg::PC_W'(1);
            end
            cpf_pkg::OP_ACC_ADD:
            begin
                if (present)
                    acc_next = acc_reg + cpf_pkg::ACC_W'(len_sel) + cpf_pkg::PREFIX_LEN;
                if (slot_reg == cpf_pkg::SLOT_PASSWORD)
                begin
                    slot_next = cpf_pkg::SLOT_CLIENT;
                    pc_next   = pc_reg + cpf_pkg::PC_W'(1);
                end
                else
                    slot_next = slot_reg + cpf_pkg::SLOT_W'(1);
            end
            cpf_pkg::OP_CONST:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = ctrl.lit;
                    pc_next   = pc_reg + cpf_pkg::PC_W'(1);
                end
            end
            cpf_pkg::OP_VARINT:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = {var_more, acc_reg[cpf_pkg::VAR_SH-1:0]};
                    acc_next  = acc_reg >> cpf_pkg::VAR_SH;
                    if (!var_more)
                        pc_next = pc_reg + cpf_pkg::PC_W'(1);
                end
            end
            cpf_pkg::OP_FLAGS:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = flags;
                    pc_next   = pc_reg + cpf_pkg::PC_W'(1);
                end
            end
            cpf_pkg::OP_KA_HI:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = ka_reg[15:8];
                    pc_next   = pc_reg + cpf_pkg::PC_W'(1);
                end
            end
            cpf_pkg::OP_KA_LO:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = ka_reg[7:0];
                    pc_next   = pc_reg + cpf_pkg::PC_W'(1);
                end
            end
            cpf_pkg::OP_SKIP:
            begin
                if (slot_reg > cpf_pkg::SLOT_PASSWORD)
                begin
                    packet_active_next = 1'b0;
                    slot_next          = cpf_pkg::SLOT_CLIENT;
                    bytes_left_next    = '0;
                    pc_next            = cpf_pkg::PC_IDLE;
                end
                else if (present)
                    pc_next = pc_reg + cpf_pkg::PC_W'(1);
                else
                    slot_next = slot_reg + cpf_pkg::SLOT_W'(1);
            end
            cpf_pkg::OP_PFX_HI:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = len_sel[15:8];
                    pc_next   = pc_reg + cpf_pkg::PC_W'(1);
                end
            end
            cpf_pkg::OP_PFX_LO:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = len_sel[7:0];
                    if (len_sel != '0)
                    begin
                        emit_last          = 1'b1;
                        packet_active_next = 1'b1;
                        bytes_left_next    = len_sel;
                        pc_next            = cpf_pkg::PC_IDLE;
                    end
                    else if (present_after)
                    begin
                        slot_next = slot_reg + cpf_pkg::SLOT_W'(1);
                        pc_next   = ctrl.jmp;
                    end
                    else
                    begin
                        emit_end           = 1'b1;
                        emit_last          = 1'b1;
                        packet_active_next = 1'b0;
                        slot_next          = cpf_pkg::SLOT_CLIENT;
                        bytes_left_next    = '0;
                        pc_next            = cpf_pkg::PC_IDLE;
                    end
                end
            end
            default:
            begin
                pc_next = cpf_pkg::PC_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_end_next   = emit_end;
            out_last_next  = emit_last;
            out_rej_next   = emit_rej;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg            <= cpf_pkg::PC_IDLE;
            acc_reg           <= '0;
            slot_reg          <= cpf_pkg::SLOT_CLIENT;
            bytes_left_reg    <= '0;
            packet_active_reg <= 1'b0;
            data_reg          <= '0;
            opt_reg           <= '0;
            ka_reg            <= '0;
            len_reg           <= '{default: '0};
            out_valid_reg     <= 1'b0;
            out_byte_reg      <= '0;
            out_end_reg       <= 1'b0;
            out_last_reg      <= 1'b0;
            out_rej_reg       <= 1'b0;
        end
        else
        begin
            pc_reg            <= pc_next;
            acc_reg           <= acc_next;
            slot_reg          <= slot_next;
            bytes_left_reg    <= bytes_left_next;
            packet_active_reg <= packet_active_next;
            data_reg          <= data_next;
            opt_reg           <= opt_next;
            ka_reg            <= ka_next;
            len_reg           <= len_next;
            out_valid_reg     <= out_valid_next;
            out_byte_reg      <= out_byte_next;
            out_end_reg       <= out_end_next;
            out_last_reg      <= out_last_next;
            out_rej_reg       <= out_rej_next;
        end
    end

    `CPF_ASSERT(a_active_has_bytes, (packet_active_reg && at_idle) |-> (bytes_left_reg != '0), "empty open string")
    `CPF_ASSERT(a_slot_range, slot_reg <= cpf_pkg::SLOT_PASSWORD, "string slot beyond password")
    `CPF_ASSERT(a_reject_form, (out_valid_reg && out_rej_reg) |-> (out_last_reg && !out_end_reg && (out_byte_reg == '0)), "malformed rejection result")
    `CPF_ASSERT(a_end_is_last, (out_valid_reg && out_end_reg) |-> out_last_reg, "frame end not last of run")
    `CPF_ASSERT_NEXT(a_accept_busy, item.valid && item.ready, pc_reg != cpf_pkg::PC_IDLE, "sequencer idle after item transfer")

endmodule
